// ===== hdl/fp8c_pkg.sv =====
// Package for the FP8 format converter: payload types, constants and the
// encode/decode functions. Depends on nothing.
`default_nettype none
package fp8c_pkg;

  localparam int unsigned FloatW = 32;
  localparam int unsigned CodeW  = 8;

  localparam logic [31:0] QnanBits    = 32'h7FC0_0000;
  localparam logic [31:0] InfBits     = 32'h7F80_0000;
  localparam logic [30:0] E4m3SatBits = 31'h43E8_0000;
  localparam logic [30:0] E5m2MaxBits = 31'h4760_0000;
  localparam logic [6:0]  E4m3MaxCode = 7'h7E;
  localparam logic [6:0]  E5m2InfCode = 7'h7C;
  localparam logic [7:0]  NanCode     = 8'h7F;

  typedef enum logic {
    FMT_E4M3 = 1'b0,
    FMT_E5M2 = 1'b1
  } fmt_e;

  typedef enum logic {
    KIND_QUANT  = 1'b0,
    KIND_DECODE = 1'b1
  } kind_e;

  localparam logic [0:0] RegFormatSelect = 1'b0;

  typedef struct packed {
    logic              kind;
    logic [FloatW-1:0] float_in;
    logic [CodeW-1:0]  code_in;
  } in_item_t;

  typedef struct packed {
    logic [CodeW-1:0]  code_out;
    logic [FloatW-1:0] value_out;
  } out_item_t;

  // Rounding shift of a 24-bit significand, ties to even; sh in 1..25.
  function automatic logic [23:0] shr_rne(input logic [23:0] v, input logic [4:0] sh);
    logic [48:0] ext;
    logic [23:0] q;
    logic        g;
    logic        st;
    ext = {1'b0, v, 24'd0} >> sh;
    q   = ext[47:24];
    g   = ext[23];
    st  = |ext[22:0];
    if (g && (st || q[0])) begin
      q = q + 24'd1;
    end
    return q;
  endfunction

  function automatic logic [7:0] fp8_encode(input logic [31:0] x, input logic e5);
    logic        s;
    logic [30:0] mag;
    logic [7:0]  ex;
    logic [23:0] sig;
    logic signed [9:0] e;
    logic signed [9:0] sh;
    logic [23:0] q;
    logic [7:0]  res;
    logic signed [9:0] bias;
    s    = x[31];
    mag  = x[30:0];
    ex   = mag[30:23];
    sig  = {(ex != 8'd0), mag[22:0]};
    e    = (ex != 8'd0) ? ($signed({2'b00, ex}) - 10'sd127) : -10'sd126;
    bias = e5 ? 10'sd15 : 10'sd7;
    res  = 8'd0;
    sh   = 10'sd0;
    q    = 24'd0;
    if (mag > InfBits[30:0]) begin
      res = NanCode;
    end else if (!e5 && mag >= E4m3SatBits) begin
      res = {s, E4m3MaxCode};
    end else if (e5 && mag > E5m2MaxBits) begin
      res = {s, E5m2InfCode};
    end else if (mag == 31'd0) begin
      res = 8'd0;
    end else if (e < 10'sd1 - bias) begin
      sh = 10'sd24 - bias - (e5 ? 10'sd2 : 10'sd3) - e;
      q  = (sh > 10'sd25) ? 24'd0 : shr_rne(sig, sh[4:0]);
      res = {s, 7'd0} | q[7:0];
    end else if (e5) begin
      q = shr_rne(sig, 5'd21);
      if (q[3]) begin
        q = q >> 1;
        e = e + 10'sd1;
      end
      res = {s, 7'd0} | {1'b0, 5'(e + bias), q[1:0]};
    end else begin
      q = shr_rne(sig, 5'd20);
      if (q[4]) begin
        q = q >> 1;
        e = e + 10'sd1;
      end
      res = {s, 7'd0} | {1'b0, 4'(e + bias), q[2:0]};
    end
    return res;
  endfunction

  function automatic logic [31:0] fp8_decode(input logic [7:0] c, input logic e5);
    logic [31:0] sgn;
    logic [4:0]  ef;
    logic [2:0]  man;
    logic [7:0]  e;
    logic [31:0] res;
    sgn = {c[7], 31'd0};
    ef  = e5 ? c[6:2] : {1'b0, c[6:3]};
    man = e5 ? {1'b0, c[1:0]} : c[2:0];
    res = sgn;
    if (!e5 && c[6:0] == 7'h7F) begin
      res = QnanBits;
    end else if (e5 && ef == 5'h1F) begin
      res = (man != 3'd0) ? QnanBits : (sgn | InfBits);
    end else if (ef == 5'd0) begin
      // Subnormal: normalize the small mantissa by its leading one.
      if (man[2]) begin
        e   = 8'(127 - 7 - 3 + 3);
        res = sgn | {1'b0, e, man[1:0], 21'd0};
      end else if (man[1]) begin
        e   = e5 ? 8'(127 - 15 - 2 + 2) : 8'(127 - 7 - 3 + 2);
        res = sgn | {1'b0, e, man[0], 22'd0};
      end else if (man[0]) begin
        e   = e5 ? 8'(127 - 15 - 2 + 1) : 8'(127 - 7 - 3 + 1);
        res = sgn | {1'b0, e, 23'd0};
      end
    end else if (e5) begin
      e   = 8'({3'd0, ef} + 8'd112);
      res = sgn | {1'b0, e, man[1:0], 21'd0};
    end else begin
      e   = 8'({3'd0, ef} + 8'd120);
      res = sgn | {1'b0, e, man, 20'd0};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fp8c_stream_if.sv =====
// Valid/ready stream interface carrying one payload type.
// Depends on nothing.
`default_nettype none
interface fp8c_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/fp8_format_converter_top.sv =====
// Top level of the FP8 format converter: register port and datapath.
// Depends on fp8c_pkg, fp8c_stream_if, fp8c_cfg and fp8c_datapath.
//
//  Channel | Direction | Payload
//  in_s    | sink      | kind, float_in, code_in
//  out_s   | source    | code_out, value_out
//  APB     | slave     | format_select at byte address 0
//
// Each item goes from input transfer into the input register, then through
// the conversion logic into the result register. A new transfer can be taken
// every cycle while the result is not stalled. Reset clears both valid flags
// and selects E4M3. A stalled result holds its register, and the input
// register keeps taking items as long as the result register can move on.
`default_nettype none
module fp8_format_converter_top import fp8c_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  fp8c_stream_if.sink      in_s,
  fp8c_stream_if.source    out_s
);
  fmt_e fmt;

  fp8c_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .fmt_o(fmt)
  );

  fp8c_datapath u_dp (
    .clk_i, .rst_ni, .fmt_i(fmt), .in_s, .out_s
  );
endmodule
`default_nettype wire

// ===== hdl/fp8c_cfg.sv =====
// APB-style register file holding the format select.
// Depends on fp8c_pkg.
`default_nettype none
module fp8c_cfg import fp8c_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output fmt_e             fmt_o
);
  fmt_e fmt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_E4M3;
    end else if (psel && penable && pwrite && paddr == RegFormatSelect) begin
      fmt_q <= fmt_e'(pwdata[0]);
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == RegFormatSelect) ? {31'd0, fmt_q} : 32'd0;
  assign fmt_o  = fmt_q;
endmodule
`default_nettype wire

// ===== hdl/fp8c_datapath.sv =====
// Input register, conversion logic and output register for the converter.
// Depends on fp8c_pkg and fp8c_stream_if.
`default_nettype none
module fp8c_datapath import fp8c_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  fmt_e      fmt_i,
  fp8c_stream_if.sink   in_s,
  fp8c_stream_if.source out_s
);
  logic      in_vld_q, out_vld_q;
  in_item_t  in_q;
  out_item_t out_q, res_d;
  logic      adv, take;
  logic [7:0] code;

  assign adv      = !out_vld_q || out_s.ready;
  assign in_s.ready = !in_vld_q || adv;
  assign take     = in_s.valid && in_s.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_s.ready) in_vld_q <= in_s.valid;
      if (adv) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) in_q <= in_s.data;
    if (adv && in_vld_q) out_q <= res_d;
  end

  always_comb begin
    code = (in_q.kind == KIND_DECODE) ? in_q.code_in
                                      : fp8_encode(in_q.float_in, fmt_i == FMT_E5M2);
    res_d.code_out  = code;
    res_d.value_out = fp8_decode(code, fmt_i == FMT_E5M2);
  end

  assign out_s.valid = out_vld_q;
  assign out_s.data  = out_q;
endmodule
`default_nettype wire
